// File: rtl/fxa_pkg.sv
`timescale 1ns / 1ps
package fxa_pkg;

  localparam int NCELL = 64;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_NEG  = 3'd2,
    CMD_CMP  = 3'd3,
    CMD_FROM = 3'd4,
    CMD_TO   = 3'd5,
    CMD_REM  = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [63:0]   rh;
    logic [63:0]   rl;
    logic          eq;
    logic          lt;
    logic          gt;
    logic          cv_neg;
    logic [127:0]  cv;
    logic          dz;
    logic [63:0]   rem;
    logic [63:0]   dvd;
    logic [63:0]   dvs;
  } beat_t;

  // count of leading zeros, 127 for a zero word
  function automatic logic [6:0] lzc128(input logic [127:0] v);
    logic [6:0] n;
    n = 7'd127;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = 7'(127 - i);
    end
    return n;
  endfunction

endpackage

// File: rtl/fxa_front.sv
`timescale 1ns / 1ps
module fxa_front
  import fxa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        src_vld,
  input  logic [2:0]  command,
  input  logic [63:0] a_int,
  input  logic [63:0] a_frac,
  input  logic [63:0] b_int,
  input  logic [63:0] b_frac,
  input  logic [63:0] float_in,
  output logic        vld,
  output beat_t       q
);

  logic         sgn;
  logic [10:0]  e;
  logic [10:0]  e1;
  logic [52:0]  m;
  logic [6:0]   sh;
  logic [10:0]  n;
  logic [116:0] tmp;
  logic         inex;
  logic [127:0] mag;
  logic [127:0] fd;
  logic [127:0] av;
  logic [127:0] bv;
  logic [127:0] sum;
  beat_t        q_next;

  // double to 64.64, floor exact with saturation
  always_comb begin
    sgn  = float_in[63];
    e    = float_in[62:52];
    m    = (e == 11'd0) ? {1'b0, float_in[51:0]} : {1'b1, float_in[51:0]};
    e1   = (e == 11'd0) ? 11'd1 : e;
    sh   = 7'(e1 - 11'd1011);
    n    = 11'd1011 - e1;
    tmp  = {m, 64'b0} >> n[5:0];
    mag  = '0;
    inex = 1'b0;
    if (e1 >= 11'd1011) begin
      mag = {75'b0, m} << sh;
    end else if (n >= 11'd64) begin
      inex = (m != '0);
    end else begin
      mag  = {75'b0, tmp[116:64]};
      inex = |tmp[63:0];
    end
    if (sgn) mag = 128'd0 - (mag + {127'b0, inex});
    if (e == 11'h7ff && float_in[51:0] != '0) begin
      fd = '0;
    end else if (e >= 11'd1086) begin
      fd = sgn ? {1'b1, 127'b0} : {1'b0, {127{1'b1}}};
    end else begin
      fd = mag;
    end
  end

  always_comb begin
    av  = {a_int, a_frac};
    bv  = {b_int, b_frac};
    sum = '0;
    q_next        = '0;
    q_next.cmd    = cmd_t'(command);
    q_next.cv_neg = av[127];
    q_next.cv     = av[127] ? 128'd0 - av : av;
    q_next.dvd    = a_frac;
    q_next.dvs    = fd[63:0];
    q_next.dz     = (fd[63:0] == '0);
    case (command)
      CMD_ADD:  sum = av + bv;
      CMD_SUB:  sum = av - bv;
      CMD_NEG:  sum = 128'd0 - av;
      CMD_FROM: sum = fd;
      default:  sum = '0;
    endcase
    q_next.rh = sum[127:64];
    q_next.rl = sum[63:0];
    if (command == CMD_CMP) begin
      q_next.eq = (av == bv);
      q_next.lt = ($signed(av) < $signed(bv));
      q_next.gt = ($signed(av) > $signed(bv));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= src_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) q <= q_next;
  end

endmodule

// File: rtl/fxa_cell.sv
`timescale 1ns / 1ps
module fxa_cell
  import fxa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  d_vld,
  input  beat_t d,
  output logic  vld,
  output beat_t q
);

  logic [64:0] t;
  beat_t       q_next;

  // one restoring step of the remainder
  always_comb begin
    q_next = d;
    t = {d.rem, d.dvd[63]};
    if (t >= {1'b0, d.dvs}) t = t - {1'b0, d.dvs};
    q_next.rem = t[63:0];
    q_next.dvd = {d.dvd[62:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) q <= q_next;
  end

endmodule

// File: rtl/fxa_norm.sv
`timescale 1ns / 1ps
module fxa_norm
  import fxa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        d_vld,
  input  beat_t       d,
  output logic        vld,
  output logic [63:0] res_int,
  output logic [63:0] res_frac,
  output logic [63:0] float_out,
  output logic        is_equal,
  output logic        is_less,
  output logic        is_greater
);

  logic [63:0]  rl0;
  logic [127:0] cv0;
  logic         cvt0;

  logic         v1, v2;
  logic [63:0]  rh1, rl1, rh2, rl2;
  logic [2:0]   fl1, fl2;
  logic         cvt1, cvt2, neg1, neg2, zero1, zero2;
  logic [127:0] cv1, nrm2;
  logic [6:0]   lz1, lz2;

  logic [53:0]  m54;
  logic         up;
  logic [10:0]  ex;
  logic [63:0]  fo;

  always_comb begin
    rl0  = d.rl;
    cv0  = d.cv;
    cvt0 = (d.cmd == CMD_TO) || (d.cmd == CMD_REM);
    if (d.cmd == CMD_REM) begin
      rl0 = d.dz ? 64'd0 : d.rem;
      cv0 = {64'b0, rl0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      vld <= 1'b0;
    end else if (adv) begin
      v1  <= d_vld;
      v2  <= v1;
      vld <= v2;
    end
  end

  // round to nearest even from the normalized word
  always_comb begin
    up  = nrm2[74] & ((|nrm2[73:0]) | nrm2[75]);
    m54 = {1'b0, nrm2[127:75]} + {53'b0, up};
    ex  = 11'd1086 - {4'b0, lz2} + {10'b0, m54[53]};
    fo  = {neg2, ex, m54[51:0]};
    if (zero2 || !cvt2) fo = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rh1   <= d.rh;
      rl1   <= rl0;
      fl1   <= {d.eq, d.lt, d.gt};
      cvt1  <= cvt0;
      neg1  <= (d.cmd == CMD_TO) && d.cv_neg;
      cv1   <= cv0;
      zero1 <= (cv0 == '0);
      lz1   <= lzc128(cv0);

      rh2   <= rh1;
      rl2   <= rl1;
      fl2   <= fl1;
      cvt2  <= cvt1;
      neg2  <= neg1;
      zero2 <= zero1;
      lz2   <= lz1;
      nrm2  <= cv1 << lz1;

      res_int    <= rh2;
      res_frac   <= rl2;
      float_out  <= fo;
      is_equal   <= fl2[2];
      is_less    <= fl2[1];
      is_greater <= fl2[0];
    end
  end

endmodule

// File: rtl/fixed_point_64_64_alu_core.sv
`timescale 1ns / 1ps
// an accepted input beat passes the front register, the 64-cell remainder
// chain, two normalize stages and the output register; a beat that waited in
// the input skid register passes through it first.
// throughput: one beat per cycle; the whole pipe holds only while out_stall
// keeps a result waiting. reset clears all valid bits and the skid full flag.
module fixed_point_64_64_alu_core
  import fxa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [63:0] a_int,
  input  logic [63:0] a_frac,
  input  logic [63:0] b_int,
  input  logic [63:0] b_frac,
  input  logic [63:0] float_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] res_int,
  output logic [63:0] res_frac,
  output logic [63:0] float_out,
  output logic        is_equal,
  output logic        is_less,
  output logic        is_greater
);

  logic        adv;
  logic        skid_full;
  logic [2:0]  sk_cmd;
  logic [63:0] sk_ai, sk_af, sk_bi, sk_bf, sk_fi;
  logic        accept;
  logic        src_vld;
  logic [2:0]  s_cmd;
  logic [63:0] s_ai, s_af, s_bi, s_bf, s_fi;

  logic        cv [NCELL+1];
  beat_t       cb [NCELL+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = skid_full;
  assign accept   = in_valid && !skid_full;
  assign src_vld  = skid_full || in_valid;

  always_comb begin
    if (skid_full) begin
      s_cmd = sk_cmd; s_ai = sk_ai; s_af = sk_af;
      s_bi  = sk_bi;  s_bf = sk_bf; s_fi = sk_fi;
    end else begin
      s_cmd = command; s_ai = a_int; s_af = a_frac;
      s_bi  = b_int;   s_bf = b_frac; s_fi = float_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && accept) begin
      sk_cmd <= command; sk_ai <= a_int; sk_af <= a_frac;
      sk_bi  <= b_int;   sk_bf <= b_frac; sk_fi <= float_in;
    end
  end

  fxa_front u_front (
    .clk, .rst, .adv, .src_vld,
    .command(s_cmd), .a_int(s_ai), .a_frac(s_af), .b_int(s_bi), .b_frac(s_bf),
    .float_in(s_fi), .vld(cv[0]), .q(cb[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fxa_cell u_cell (
      .clk, .rst, .adv,
      .d_vld(cv[i]), .d(cb[i]), .vld(cv[i+1]), .q(cb[i+1])
    );
  end

  fxa_norm u_norm (
    .clk, .rst, .adv,
    .d_vld(cv[NCELL]), .d(cb[NCELL]), .vld(out_valid),
    .res_int, .res_frac, .float_out, .is_equal, .is_less, .is_greater
  );

`ifndef SYNTHESIS
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({is_equal, is_less, is_greater}))
    else $error("more than one compare flag");
  a_float_no_int: assert property (@(posedge clk) disable iff (rst)
    out_valid && float_out != 64'd0 |-> res_int == 64'd0)
    else $error("float result with nonzero integer part");
  a_flags_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_equal || is_less || is_greater) |->
      res_int == 64'd0 && res_frac == 64'd0 && float_out == 64'd0)
    else $error("compare beat carries other fields");
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_full && !adv |=> skid_full)
    else $error("skid beat lost while pipe held");
`endif

endmodule
